FILE: src/acrd_pkg.sv
// Shared constants and types for the adaptive cubature refinement decision block.
// No dependencies; imported by acrd_fpadd and adaptive_cubature_refine_decision.
`default_nettype none

package acrd_pkg;

    localparam int DIMS           = 3;
    localparam int MAX_COMPONENTS = 16;
    localparam int NCHILD         = 1 << DIMS;
    localparam int CHILD_W        = (DIMS > 0) ? DIMS : 1;
    localparam int COMP_W         = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int COUNT_W        = $clog2(MAX_COMPONENTS + 1);

    localparam logic [1:0] REG_STEP_NUMBER     = 2'd0;
    localparam logic [1:0] REG_MINIMUM_STEPS   = 2'd1;
    localparam logic [1:0] REG_MAXIMUM_STEPS   = 2'd2;
    localparam logic [1:0] REG_COMPONENT_COUNT = 2'd3;

    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_TOTAL    = 1'b1;

    localparam logic [63:0] DBL_POS_ZERO    = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    typedef struct packed {
        logic start;
        logic sub;
    } add_req_t;

    // IEEE equality: NaN never equal, the two zeros equal.
    function automatic logic dbl_equal(input logic [63:0] a, input logic [63:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        return !a_nan && !b_nan && ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
    endfunction

endpackage

`default_nettype wire

FILE: src/acrd_fpadd.sv
// Pipelined double precision adder/subtractor, round to nearest even.
// Depends on acrd_pkg for the request struct and NaN constant.
`default_nettype none

module acrd_fpadd
    import acrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire add_req_t    req,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      result
);

    // Stage 1: special operands and alignment
    logic        a_nan, b_nan, a_inf, b_inf, sb_eff, a_big;
    logic        sp_hit;
    logic [63:0] sp_val;
    logic        sl, ss;
    logic [10:0] el, es, dexp;
    logic [52:0] ml, ms;
    logic [55:0] b_ext, b_sh, b_mask;
    logic        b_sticky;

    always_comb
    begin
        a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
        b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
        sb_eff = b[63] ^ req.sub;
        sp_hit = 1'b1;
        sp_val = DBL_DEFAULT_NAN;
        if (a_nan)
            sp_val = a | 64'h0008_0000_0000_0000;
        else if (b_nan)
            sp_val = b | 64'h0008_0000_0000_0000;
        else if (a_inf && b_inf && (a[63] != sb_eff))
            sp_val = DBL_DEFAULT_NAN;
        else if (a_inf)
            sp_val = a;
        else if (b_inf)
            sp_val = {sb_eff, b[62:0]};
        else
            sp_hit = 1'b0;

        a_big = (a[62:0] >= b[62:0]);
        if (a_big)
        begin
            sl = a[63];
            ss = sb_eff;
            el = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
            es = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
            ml = {(a[62:52] != 11'd0), a[51:0]};
            ms = {(b[62:52] != 11'd0), b[51:0]};
        end
        else
        begin
            sl = sb_eff;
            ss = a[63];
            el = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
            es = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
            ml = {(b[62:52] != 11'd0), b[51:0]};
            ms = {(a[62:52] != 11'd0), a[51:0]};
        end
        dexp   = el - es;
        b_ext  = {ms, 3'b000};
        b_mask = '0;
        if (dexp >= 11'd56)
        begin
            b_sh     = 56'd0;
            b_sticky = (ms != 53'd0);
        end
        else
        begin
            b_mask   = ~({56{1'b1}} << dexp[5:0]);
            b_sh     = b_ext >> dexp[5:0];
            b_sticky = ((b_ext & b_mask) != 56'd0);
        end
    end

    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic        s1_sp_reg, s2_sp_reg, s3_sp_reg;
    logic [63:0] s1_spv_reg, s2_spv_reg, s3_spv_reg;
    logic        s1_sign_reg, s2_sign_reg, s3_sign_reg;
    logic        s1_subop_reg, s2_subop_reg;
    logic [11:0] s1_exp_reg, s2_exp_reg, s3_exp_reg;
    logic [55:0] s1_a_reg, s1_b_reg, s3_n_reg;
    logic [56:0] s2_sum_reg;
    logic        s3_zero_reg;
    logic [63:0] result_reg;

    // Stage 3: normalisation
    logic [5:0]  lzc;
    logic [11:0] nsh;
    logic [55:0] n_val;
    logic [11:0] n_exp;

    always_comb
    begin
        lzc = 6'd56;
        for (int i = 0; i < 56; i++)
        begin
            if (s2_sum_reg[i])
                lzc = 6'(55 - i);
        end
        if (s2_sum_reg[56])
        begin
            nsh   = 12'd0;
            n_val = {s2_sum_reg[56:2], |s2_sum_reg[1:0]};
            n_exp = s2_exp_reg + 12'd1;
        end
        else
        begin
            nsh   = ({6'd0, lzc} < (s2_exp_reg - 12'd1)) ? {6'd0, lzc}
                                                         : (s2_exp_reg - 12'd1);
            n_val = s2_sum_reg[55:0] << nsh[5:0];
            n_exp = s2_exp_reg - nsh;
        end
    end

    // Stage 4: rounding and packing
    logic        rnd_up;
    logic [53:0] m_r;
    logic [11:0] e_fin;
    logic [51:0] f_fin;
    logic [63:0] packed_val;

    always_comb
    begin
        rnd_up = s3_n_reg[2] && (s3_n_reg[1] || s3_n_reg[0] || s3_n_reg[3]);
        m_r    = {1'b0, s3_n_reg[55:3]} + {53'd0, rnd_up};
        if (m_r[53])
        begin
            e_fin = s3_exp_reg + 12'd1;
            f_fin = m_r[52:1];
        end
        else if (m_r[52])
        begin
            e_fin = s3_exp_reg;
            f_fin = m_r[51:0];
        end
        else
        begin
            e_fin = 12'd0;
            f_fin = m_r[51:0];
        end
        if (s3_sp_reg)
            packed_val = s3_spv_reg;
        else if (s3_zero_reg)
            packed_val = {s3_sign_reg, 63'd0};
        else if (e_fin >= 12'd2047)
            packed_val = {s3_sign_reg, 11'h7FF, 52'd0};
        else
            packed_val = {s3_sign_reg, e_fin[10:0], f_fin};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= req.start;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sp_reg    <= sp_hit;
        s1_spv_reg   <= sp_val;
        s1_sign_reg  <= sl;
        s1_subop_reg <= (sl != ss);
        s1_exp_reg   <= {1'b0, el};
        s1_a_reg     <= {ml, 3'b000};
        s1_b_reg     <= {b_sh[55:1], b_sh[0] | b_sticky};

        s2_sp_reg    <= s1_sp_reg;
        s2_spv_reg   <= s1_spv_reg;
        s2_sign_reg  <= s1_sign_reg;
        s2_subop_reg <= s1_subop_reg;
        s2_exp_reg   <= s1_exp_reg;
        s2_sum_reg   <= s1_subop_reg ? ({1'b0, s1_a_reg} - {1'b0, s1_b_reg})
                                     : ({1'b0, s1_a_reg} + {1'b0, s1_b_reg});

        s3_sp_reg    <= s2_sp_reg;
        s3_spv_reg   <= s2_spv_reg;
        // An exact cancellation gives positive zero; zeros of one sign keep it.
        s3_sign_reg  <= (s2_sum_reg == 57'd0 && s2_subop_reg) ? 1'b0 : s2_sign_reg;
        s3_zero_reg  <= (s2_sum_reg == 57'd0);
        s3_n_reg     <= n_val;
        s3_exp_reg   <= n_exp;

        result_reg   <= packed_val;
    end

    assign done   = s4_vld_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !s1_vld_reg && !s2_vld_reg && !s3_vld_reg)
        else $error("adder restarted while busy");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> ##4 done)
        else $error("adder result not on time");
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req.start, 4))
        else $error("adder result without request");
`endif

endmodule

`default_nettype wire

FILE: src/adaptive_cubature_refine_decision.sv
// Top level: Kahan child sums, refinement decision and pass totals.
// Depends on acrd_pkg and the shared adder acrd_fpadd.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | child_integral, parent_estimate, tolerance_guess,
//          |                      | last_cell
//  out     | out_valid / out_stall| result_kind, refine_cell, component, total_value,
//          |                      | last
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// Every double addition runs through one adder, one at a time.
// A child item takes four dependent Kahan additions; the last child of a component
// adds two more, an accepted cell end one per accumulated component, and each
// result waits for the output register to be free.
// The input is stalled until the item's work and results are all handed over.
// Reset clears the counters and the valid bits of the sum stores at once.
`default_nettype none

module adaptive_cubature_refine_decision
    import acrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] child_integral,
    input  wire logic [63:0] parent_estimate,
    input  wire logic [63:0] tolerance_guess,
    input  wire logic        last_cell,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic             refine_cell,
    output logic [3:0]       component,
    output logic [63:0]      total_value,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_Y, S_T, S_U, S_K, S_D, S_G,
        S_ACC_RD, S_ACC_GO, S_ACC_W, S_DEC, S_TOT_RD, S_TOT_OUT
    } state_t;

    state_t               state_reg;
    logic [7:0]           step_reg, min_reg, max_reg;
    logic [4:0]           count_reg;
    logic [CHILD_W-1:0]   child_cnt_reg;
    logic [COMP_W-1:0]    comp_cnt_reg, idx_reg;
    logic                 pend_reg, first_reg, endp_reg, refine_reg;
    logic [63:0]          x_reg, est_reg, guess_reg, y_reg, t_reg;
    logic [MAX_COMPONENTS-1:0] sum_vld_reg, comp_vld_reg, pass_vld_reg;

    logic                 out_valid_reg, kind_reg, orefine_reg, last_reg;
    logic [3:0]           ocomp_reg;
    logic [63:0]          total_reg;

    logic [63:0] sum_mem  [MAX_COMPONENTS];
    logic [63:0] comp_mem [MAX_COMPONENTS];
    logic [63:0] pass_mem [MAX_COMPONENTS];
    logic [63:0] sum_rd_reg, comp_rd_reg, pass_rd_reg;
    logic        sum_rdv_reg, comp_rdv_reg, pass_rdv_reg;

    add_req_t    add_req;
    logic [63:0] add_a, add_b, add_res;
    logic        add_done;
    logic        add_start_reg, add_sub_reg;
    logic [63:0] add_a_reg, add_b_reg;

    logic [COUNT_W-1:0] eff_count;
    logic [63:0]        s_val, k_val, sum_val, pass_val;
    logic               accept_in, out_free, mismatch, refine_c, final_c;
    logic               comp_last, idx_last;

    acrd_fpadd u_add (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (add_req),
        .a      (add_a),
        .b      (add_b),
        .done   (add_done),
        .result (add_res)
    );

    assign add_req.start = add_start_reg;
    assign add_req.sub   = add_sub_reg;
    assign add_a         = add_a_reg;
    assign add_b         = add_b_reg;

    always_comb
    begin
        if (count_reg == 5'd0)
            eff_count = COUNT_W'(1);
        else if ({{(32-5){1'b0}}, count_reg} > 32'(MAX_COMPONENTS))
            eff_count = COUNT_W'(MAX_COMPONENTS);
        else
            eff_count = COUNT_W'(count_reg);
        s_val     = first_reg ? DBL_POS_ZERO : (sum_rdv_reg ? sum_rd_reg : DBL_POS_ZERO);
        k_val     = comp_rdv_reg ? comp_rd_reg : DBL_POS_ZERO;
        sum_val   = sum_rdv_reg ? sum_rd_reg : DBL_POS_ZERO;
        pass_val  = pass_rdv_reg ? pass_rd_reg : DBL_POS_ZERO;
        accept_in = in_valid && (state_reg == S_IDLE);
        out_free  = !out_valid_reg || !out_stall;
        mismatch  = !dbl_equal(add_res, guess_reg);
        refine_c  = pend_reg || mismatch || (step_reg < min_reg);
        final_c   = (max_reg == 8'd0) || (step_reg >= max_reg - 8'd1);
        comp_last = ({1'b0, comp_cnt_reg} + 1'b1) >= eff_count;
        idx_last  = ({1'b0, idx_reg} + 1'b1) >= eff_count;
    end

    // Sum, compensation and total stores; reads are registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_K && add_done)
        begin
            sum_mem[comp_cnt_reg]  <= t_reg;
            comp_mem[comp_cnt_reg] <= add_res;
        end
        if (state_reg == S_ACC_W && add_done)
            pass_mem[idx_reg] <= add_res;
        if (state_reg == S_IDLE)
        begin
            sum_rd_reg   <= sum_mem[comp_cnt_reg];
            sum_rdv_reg  <= sum_vld_reg[comp_cnt_reg];
            comp_rd_reg  <= comp_mem[comp_cnt_reg];
            comp_rdv_reg <= comp_vld_reg[comp_cnt_reg];
        end
        else if (state_reg == S_ACC_RD)
        begin
            sum_rd_reg  <= sum_mem[idx_reg];
            sum_rdv_reg <= sum_vld_reg[idx_reg];
        end
        if (state_reg == S_ACC_RD || state_reg == S_TOT_RD)
        begin
            pass_rd_reg  <= pass_mem[idx_reg];
            pass_rdv_reg <= pass_vld_reg[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            x_reg     <= child_integral;
            est_reg   <= parent_estimate;
            guess_reg <= tolerance_guess;
            endp_reg  <= last_cell;
        end
        if (state_reg == S_Y && add_done)
            y_reg <= add_res;
        if (state_reg == S_T && add_done)
            t_reg <= add_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 8'd0;
            min_reg       <= 8'd0;
            max_reg       <= 8'd0;
            count_reg     <= 5'd1;
            child_cnt_reg <= '0;
            comp_cnt_reg  <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            refine_reg    <= 1'b0;
            sum_vld_reg   <= '0;
            comp_vld_reg  <= '0;
            pass_vld_reg  <= '0;
            add_start_reg <= 1'b0;
            add_sub_reg   <= 1'b0;
            add_a_reg     <= '0;
            add_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_DECISION;
            orefine_reg   <= 1'b0;
            ocomp_reg     <= 4'd0;
            total_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            add_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP_NUMBER:     step_reg  <= cfg_data;
                    REG_MINIMUM_STEPS:   min_reg   <= cfg_data;
                    REG_MAXIMUM_STEPS:   max_reg   <= cfg_data;
                    REG_COMPONENT_COUNT: count_reg <= cfg_data[4:0];
                    default:             ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        first_reg <= (child_cnt_reg == '0);
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    add_a_reg     <= x_reg;
                    add_b_reg     <= k_val;
                    add_sub_reg   <= 1'b1;
                    add_start_reg <= 1'b1;
                    state_reg     <= S_Y;
                end
                S_Y:
                begin
                    if (add_done)
                    begin
                        add_a_reg     <= s_val;
                        add_b_reg     <= add_res;
                        add_sub_reg   <= 1'b0;
                        add_start_reg <= 1'b1;
                        state_reg     <= S_T;
                    end
                end
                S_T:
                begin
                    if (add_done)
                    begin
                        add_a_reg     <= add_res;
                        add_b_reg     <= s_val;
                        add_sub_reg   <= 1'b1;
                        add_start_reg <= 1'b1;
                        state_reg     <= S_U;
                    end
                end
                S_U:
                begin
                    if (add_done)
                    begin
                        add_a_reg     <= add_res;
                        add_b_reg     <= y_reg;
                        add_sub_reg   <= 1'b1;
                        add_start_reg <= 1'b1;
                        state_reg     <= S_K;
                    end
                end
                S_K:
                begin
                    if (add_done)
                    begin
                        sum_vld_reg[comp_cnt_reg]  <= 1'b1;
                        comp_vld_reg[comp_cnt_reg] <= 1'b1;
                        if (child_cnt_reg != CHILD_W'(NCHILD - 1))
                        begin
                            child_cnt_reg <= child_cnt_reg + 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            child_cnt_reg <= '0;
                            add_a_reg     <= est_reg;
                            add_b_reg     <= t_reg;
                            add_sub_reg   <= 1'b1;
                            add_start_reg <= 1'b1;
                            state_reg     <= S_D;
                        end
                    end
                end
                S_D:
                begin
                    if (add_done)
                    begin
                        add_a_reg     <= guess_reg;
                        add_b_reg     <= add_res;
                        add_sub_reg   <= 1'b0;
                        add_start_reg <= 1'b1;
                        state_reg     <= S_G;
                    end
                end
                S_G:
                begin
                    if (add_done)
                    begin
                        if (!comp_last)
                        begin
                            pend_reg     <= pend_reg || mismatch;
                            comp_cnt_reg <= comp_cnt_reg + 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            refine_reg <= refine_c && !final_c;
                            idx_reg    <= '0;
                            state_reg  <= (!refine_c || final_c) ? S_ACC_RD : S_DEC;
                        end
                    end
                end
                S_ACC_RD:
                begin
                    state_reg <= S_ACC_GO;
                end
                S_ACC_GO:
                begin
                    add_a_reg     <= pass_val;
                    add_b_reg     <= sum_val;
                    add_sub_reg   <= 1'b0;
                    add_start_reg <= 1'b1;
                    state_reg     <= S_ACC_W;
                end
                S_ACC_W:
                begin
                    if (add_done)
                    begin
                        pass_vld_reg[idx_reg] <= 1'b1;
                        if (idx_last)
                            state_reg <= S_DEC;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_ACC_RD;
                        end
                    end
                end
                S_DEC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_DECISION;
                        orefine_reg   <= refine_reg;
                        ocomp_reg     <= 4'd0;
                        total_reg     <= DBL_POS_ZERO;
                        last_reg      <= !endp_reg;
                        comp_cnt_reg  <= '0;
                        pend_reg      <= 1'b0;
                        idx_reg       <= '0;
                        state_reg     <= endp_reg ? S_TOT_RD : S_IDLE;
                    end
                end
                S_TOT_RD:
                begin
                    state_reg <= S_TOT_OUT;
                end
                S_TOT_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_TOTAL;
                        orefine_reg   <= 1'b0;
                        ocomp_reg     <= 4'(idx_reg);
                        total_reg     <= pass_val;
                        last_reg      <= idx_last;
                        if (idx_last)
                        begin
                            // Pass end: totals and compensation go back to zero.
                            pass_vld_reg  <= '0;
                            comp_vld_reg  <= '0;
                            child_cnt_reg <= '0;
                            comp_cnt_reg  <= '0;
                            pend_reg      <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_TOT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign refine_cell = orefine_reg;
    assign component   = ocomp_reg;
    assign total_value = total_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_idle_no_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !add_done)
        else $error("adder result arrived with no item in work");
    a_total_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOT_OUT) |-> endp_reg)
        else $error("totals emitted for a cell that does not end the pass");
    a_pass_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOT_OUT && out_free && idx_last) |=>
            (state_reg == S_IDLE && pass_vld_reg == '0 && comp_vld_reg == '0))
        else $error("pass state not cleared after the final total");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_adaptive_cubature_refine_decision.sv
// Self-checking testbench for adaptive_cubature_refine_decision: random and directed cells,
// checked against an in-bench predictor of the Kahan sums, decisions and pass totals.
// Depends on acrd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_adaptive_cubature_refine_decision
    import acrd_pkg::*;
;

    typedef struct {
        logic [63:0] child;
        logic [63:0] parent;
        logic [63:0] guess;
        logic        lastc;
    } child_item_t;

    typedef struct {
        logic        kind;
        logic        refine;
        logic [3:0]  comp;
        logic [63:0] total;
        logic        last;
    } cell_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] child_integral;
    logic [63:0] parent_estimate;
    logic [63:0] tolerance_guess;
    logic        last_cell;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic        refine_cell;
    logic [3:0]  component;
    logic [63:0] total_value;
    logic        last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    adaptive_cubature_refine_decision dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .child_integral(child_integral), .parent_estimate(parent_estimate),
        .tolerance_guess(tolerance_guess), .last_cell(last_cell),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .refine_cell(refine_cell), .component(component),
        .total_value(total_value), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    child_item_t  pending_children[$];
    cell_result_t expected_results[$];

    // Predictor copy of the block's registers and state.
    logic [7:0] step_reg;
    logic [7:0] min_steps_reg;
    logic [7:0] max_steps_reg;
    logic [4:0] count_reg;
    real        comp_sum[MAX_COMPONENTS];
    real        kahan_comp[MAX_COMPONENTS];
    real        pass_sum[MAX_COMPONENTS];
    int         child_pos;
    int         comp_idx;
    bit         refine_seen;

    int  send_idle_pct;
    int  stall_pct;
    bit  hold_request;
    int  hold_left;
    int  mismatches;
    int  items_in;
    int  results_out;
    int  decisions_refined;
    int  totals_seen;
    int  quiet_cycles;

    function automatic int active_count();
        if (count_reg == 5'd0)
            return 1;
        if (count_reg > MAX_COMPONENTS)
            return MAX_COMPONENTS;
        return int'(count_reg);
    endfunction

    function automatic bit is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    task automatic clear_pass_state();
        for (int i = 0; i < MAX_COMPONENTS; i++)
        begin
            kahan_comp[i] = 0.0;
            pass_sum[i] = 0.0;
        end
        child_pos = 0;
        comp_idx = 0;
        refine_seen = 1'b0;
    endtask

    task automatic predict_cell_step(input child_item_t it);
        int          cnt;
        int          c;
        real         y;
        real         t;
        real         s;
        real         est;
        real         g;
        bit          refine;
        bit          final_step;
        bit          accept;
        cell_result_t r;
        cnt = active_count();
        c = comp_idx;
        if (c >= MAX_COMPONENTS)
            c = MAX_COMPONENTS - 1;
        if (child_pos == 0)
            comp_sum[c] = 0.0;
        s = comp_sum[c];
        y = $bitstoreal(it.child) - kahan_comp[c];
        t = s + y;
        kahan_comp[c] = (t - s) - y;
        comp_sum[c] = t;
        if (child_pos + 1 < NCHILD)
        begin
            child_pos++;
            return;
        end
        child_pos = 0;
        est = $bitstoreal(it.parent);
        g = $bitstoreal(it.guess);
        if (!(g + (est - comp_sum[c]) == g))
            refine_seen = 1'b1;
        if (c + 1 < cnt)
        begin
            comp_idx = c + 1;
            return;
        end
        refine = refine_seen || (int'(step_reg) < int'(min_steps_reg));
        final_step = int'(step_reg) >= int'(max_steps_reg) - 1;
        accept = !refine || final_step;
        if (accept)
            for (int i = 0; i < cnt; i++)
                pass_sum[i] = pass_sum[i] + comp_sum[i];
        r.kind = KIND_DECISION;
        r.refine = refine && !final_step;
        r.comp = 4'd0;
        r.total = DBL_POS_ZERO;
        r.last = !it.lastc;
        expected_results = {expected_results, r};
        comp_idx = 0;
        refine_seen = 1'b0;
        if (it.lastc)
        begin
            for (int i = 0; i < cnt; i++)
            begin
                r.kind = KIND_TOTAL;
                r.refine = 1'b0;
                r.comp = 4'(i);
                r.total = $realtobits(pass_sum[i]);
                r.last = (i + 1 == cnt);
                expected_results = {expected_results, r};
            end
            clear_pass_state();
        end
    endtask

    // Sender: one nonblocking update per signal per edge.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_children.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                child_item_t nx;
                nx = pending_children.pop_front();
                in_valid <= 1'b1;
                child_integral <= nx.child;
                parent_estimate <= nx.parent;
                tolerance_guess <= nx.guess;
                last_cell <= nx.lastc;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus an occasional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && hold_left == 0)
                hold_left <= 400;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
                if (hold_left == 1)
                    hold_request = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: predict on accepted input items, check accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            bit moved;
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                child_item_t acc;
                acc.child = child_integral;
                acc.parent = parent_estimate;
                acc.guess = tolerance_guess;
                acc.lastc = last_cell;
                predict_cell_step(acc);
                items_in++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                results_out++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0b refine %0b comp %0d total %h",
                                 result_kind, refine_cell, component, total_value);
                end
                else
                begin
                    cell_result_t e;
                    e = expected_results.pop_front();
                    if (e.kind == KIND_TOTAL)
                        totals_seen++;
                    else if (e.refine)
                        decisions_refined++;
                    // Any NaN pattern stands for any other.
                    if (result_kind !== e.kind || refine_cell !== e.refine ||
                        component !== e.comp || last !== e.last ||
                        !(total_value === e.total ||
                          (is_nan(total_value) && is_nan(e.total))))
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp kind %0b ref %0b comp %0d total %h last %0b",
                                     e.kind, e.refine, e.comp, e.total, e.last);
                            $display("          got kind %0b ref %0b comp %0d total %h last %0b",
                                     result_kind, refine_cell, component, total_value,
                                     last);
                        end
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles > 20000)
        begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("tb_adaptive_cubature_refine_decision failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEP_NUMBER:     step_reg = val;
            REG_MINIMUM_STEPS:   min_steps_reg = val;
            REG_MAXIMUM_STEPS:   max_steps_reg = val;
            REG_COMPONENT_COUNT: count_reg = val[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] st, input logic [7:0] mn,
                             input logic [7:0] mx, input logic [7:0] cnt);
        write_reg(REG_STEP_NUMBER, st);
        write_reg(REG_MINIMUM_STEPS, mn);
        write_reg(REG_MAXIMUM_STEPS, mx);
        write_reg(REG_COMPONENT_COUNT, cnt);
    endtask

    task automatic wait_idle();
        while (pending_children.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        // Items that end no cell may still be in flight.
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [63:0] random_bits();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] random_value();
        if ($urandom_range(19) == 0)
            return random_bits();
        return $realtobits((real'($urandom_range(2000000)) - 1000000.0) / 1024.0);
    endfunction

    // Queues one cell; each component's guess is huge (usually accepted) or a random value.
    task automatic queue_cell(input int comps, input bit final_cell);
        child_item_t it;
        bit          loose;
        for (int c = 0; c < comps; c++)
        begin
            loose = ($urandom_range(99) < 60);
            for (int k = 0; k < NCHILD; k++)
            begin
                it.child = random_value();
                if (k == NCHILD - 1)
                begin
                    it.parent = random_value();
                    it.guess = loose ? $realtobits(1.0e30) : random_value();
                end
                else
                begin
                    it.parent = random_bits();
                    it.guess = random_bits();
                end
                it.lastc = (k == NCHILD - 1 && c == comps - 1) ? final_cell
                                                                : $urandom_range(1);
                pending_children = {pending_children, it};
            end
        end
    endtask

    task automatic queue_passes(input int n_items);
        int budget;
        int cells;
        int cnt;
        budget = n_items;
        cnt = active_count();
        while (budget > 0)
        begin
            cells = $urandom_range(1, 3);
            for (int i = 0; i < cells; i++)
                queue_cell(cnt, i == cells - 1);
            budget -= cells * cnt * NCHILD;
        end
    endtask

    task automatic queue_directed_cell(input logic [63:0] v, input logic [63:0] p,
                                       input logic [63:0] g, input bit final_cell);
        child_item_t it;
        for (int k = 0; k < NCHILD; k++)
        begin
            it.child = v;
            it.parent = p;
            it.guess = g;
            it.lastc = final_cell;
            pending_children = {pending_children, it};
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        child_integral = '0;
        parent_estimate = '0;
        tolerance_guess = '0;
        last_cell = 1'b0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_STEP_NUMBER;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        mismatches = 0;
        items_in = 0;
        results_out = 0;
        decisions_refined = 0;
        totals_seen = 0;
        quiet_cycles = 0;
        step_reg = 8'd0;
        min_steps_reg = 8'd0;
        max_steps_reg = 8'd0;
        count_reg = 5'd1;
        for (int i = 0; i < MAX_COMPONENTS; i++)
            comp_sum[i] = 0.0;
        clear_pass_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zeros, all ones, NaN, infinity, exact and missed estimates.
        queue_directed_cell(DBL_POS_ZERO, DBL_POS_ZERO, DBL_POS_ZERO, 1'b0);
        queue_directed_cell(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                            64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        queue_directed_cell($realtobits(1.0), $realtobits(8.0), $realtobits(1.0), 1'b1);
        wait_idle();
        configure(8'd3, 8'd0, 8'd255, 8'd1);
        queue_directed_cell(64'h7FF0_0000_0000_0000, DBL_POS_ZERO, $realtobits(1.0), 1'b0);
        queue_directed_cell($realtobits(0.5), $realtobits(4.0), $realtobits(1.0e30), 1'b1);
        wait_idle();

        configure(8'd5, 8'd3, 8'd10, 8'd2);
        queue_passes(40);
        wait_idle();

        send_idle_pct = 61;
        configure(8'd1, 8'd4, 8'd255, 8'd3);
        queue_passes(40);
        wait_idle();

        // Receiver stalls; a long hold-off lets the block back up.
        send_idle_pct = 0;
        stall_pct = 61;
        configure(8'd255, 8'd255, 8'd0, 8'd0);
        hold_request = 1'b1;
        queue_passes(40);
        wait_idle();

        send_idle_pct = 18;
        stall_pct = 18;
        configure(8'd200, 8'd0, 8'd201, 8'd20);
        queue_cell(active_count(), 1'b1);
        wait_idle();

        configure(8'd0, 8'd0, 8'd1, 8'd1);
        queue_passes(24);
        wait_idle();

        send_idle_pct = 0;
        stall_pct = 0;
        configure(8'd7, 8'd7, 8'd9, 8'd16);
        queue_cell(2, 1'b0);
        // Count drops mid-cell, so the cell ends with its next component.
        wait_idle();
        configure(8'd7, 8'd7, 8'd9, 8'd1);
        queue_passes(16);
        wait_idle();

        $display("Covered %0d input items and %0d results (%0d refine decisions, %0d totals).",
                 items_in, results_out, decisions_refined, totals_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_adaptive_cubature_refine_decision passed");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("tb_adaptive_cubature_refine_decision failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/acrd_pkg.sv
src/acrd_fpadd.sv
src/adaptive_cubature_refine_decision.sv
tb/tb_adaptive_cubature_refine_decision.sv
